@@ hdl/spc_pkg.sv @@
`timescale 1ns / 1ps

package spc_pkg;

    localparam int MAX_N_DEF = 65535;
    localparam int LIMIT_W   = 16;
    localparam int COUNT_W   = 16;
    // wide enough to hold n + i for any n, i below 2^16
    localparam int IDX_W     = 17;
    // holds (i+1)^2 for i up to 2^16 - 1
    localparam int SQ_W      = 33;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

endpackage

@@ hdl/spc_ram.sv @@
`timescale 1ns / 1ps

module spc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/spc_core.sv @@
`timescale 1ns / 1ps

module spc_core #(
    parameter int MAX_N = spc_pkg::MAX_N_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [spc_pkg::LIMIT_W-1:0] limit,
    input  logic                        ack,
    output spc_pkg::core_stat_t         stat,
    output logic [spc_pkg::COUNT_W-1:0] count
);

    import spc_pkg::*;

    localparam int DEPTH = MAX_N + 1;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FILL = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_CLR  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [LIMIT_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   p_reg, p_next;
    logic [SQ_W-1:0]    sq_reg, sq_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [LIMIT_W-1:0] n_sat;
    logic [IDX_W-1:0]   n_ext;
    logic [IDX_W-1:0]   p_step;
    logic [IDX_W-1:0]   addr_idx;
    logic               mem_we;
    logic               mem_wdata;
    logic               mem_rdata;
    logic               last_i;

    assign n_sat  = ({16'd0, limit} > 32'(MAX_N)) ? LIMIT_W'(MAX_N) : limit;
    assign n_ext  = IDX_W'(n_reg);
    assign p_step = p_reg + i_reg;
    assign last_i = (i_reg == n_ext);

    spc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_flags (
        .clk   (clk),
        .we    (mem_we),
        .addr  (AW'(addr_idx)),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        p_next     = p_reg;
        sq_next    = sq_reg;
        count_next = count_reg;
        addr_idx   = i_reg;
        mem_we     = 1'b0;
        mem_wdata  = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next     = n_sat;
                    i_next     = '0;
                    count_next = '0;
                    state_next = (n_sat < LIMIT_W'(2)) ? ST_DONE : ST_FILL;
                end
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = 1'b1;
                if (last_i)
                begin
                    i_next     = IDX_W'(2);
                    sq_next    = SQ_W'(4);
                    state_next = ST_RD;
                end
                else
                begin
                    i_next = i_reg + IDX_W'(1);
                end
            end
            ST_RD:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (mem_rdata && (sq_reg <= SQ_W'(n_reg)))
                begin
                    count_next = count_reg + COUNT_W'(1);
                    p_next     = IDX_W'(sq_reg);
                    state_next = ST_CLR;
                end
                else
                begin
                    if (mem_rdata)
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    i_next     = i_reg + IDX_W'(1);
                    sq_next    = sq_reg + SQ_W'({i_reg, 1'b1});
                    state_next = last_i ? ST_DONE : ST_RD;
                end
            end
            ST_CLR:
            begin
                addr_idx  = p_reg;
                mem_we    = 1'b1;
                mem_wdata = 1'b0;
                p_next    = p_step;
                if (p_step > n_ext)
                begin
                    i_next     = i_reg + IDX_W'(1);
                    sq_next    = sq_reg + SQ_W'({i_reg, 1'b1});
                    state_next = last_i ? ST_DONE : ST_RD;
                end
            end
            ST_DONE:
            begin
                if (ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        i_reg     <= i_next;
        p_reg     <= p_next;
        sq_reg    <= sq_next;
        count_reg <= count_next;
    end

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);
    assign count     = count_reg;

endmodule

@@ hdl/sieve_prime_counter.sv @@
// Steps per beat, accepting edge to out_valid, for n >= 2: a flag fill of indices 0 to n,
// then a read state and a check state per scanned index, a clear per cleared multiple (a little
// under n*ln(ln n) of them), then a load of the output register; for n < 2 only the load.
// Throughput: one beat at a time, bounded by the single port of the flag RAM.
// A new beat is taken as soon as the previous result sits in the output register.
// Reset clears control state only; the flag RAM is refilled at the start of every beat with n >= 2.
`timescale 1ns / 1ps

module sieve_prime_counter #(
    parameter int MAX_N = spc_pkg::MAX_N_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [spc_pkg::LIMIT_W-1:0] limit,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [spc_pkg::COUNT_W-1:0] prime_count
);

    import spc_pkg::*;

    core_stat_t         stat;
    logic [COUNT_W-1:0] core_count;
    logic               start;
    logic               load;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] prime_count_reg;

    assign in_stall = stat.busy;
    assign start    = in_valid && !stat.busy;
    assign load     = stat.done && (!out_valid_reg || !out_stall);

    spc_core #(
        .MAX_N (MAX_N)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .limit (limit),
        .ack   (load),
        .stat  (stat),
        .count (core_count)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prime_count_reg <= core_count;
        end
    end

    assign out_valid   = out_valid_reg;
    assign prime_count = prime_count_reg;

endmodule
